// ===== rtl/core/tod_pkg.sv =====
// Package for the tilt orientation detector.
// Holds field widths, register codes, orientation codes and reset values.
// No dependencies; used by the top level, the checker and the testbench.
package tod_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 6;
  localparam int unsigned THRESH_W = 6;
  localparam int unsigned ROUNDS_W = 4;
  localparam int unsigned ORIENT_W = 3;

  // Configuration port geometry
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  // Default window size
  localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 8;

  // Register reset values
  localparam logic [THRESH_W-1:0] THRESH_RST = 6'd10;
  localparam logic [ROUNDS_W-1:0] ROUNDS_RST = 4'd8;

  // Register indexes
  typedef enum logic {
    REG_THRESHOLD      = 1'b0,
    REG_CONFIRM_ROUNDS = 1'b1
  } reg_idx_t;

  // Orientation codes
  typedef enum logic [ORIENT_W-1:0] {
    ORIENT_UNKNOWN = 3'd0,
    ORIENT_LEFT    = 3'd1,
    ORIENT_RIGHT   = 3'd2,
    ORIENT_FRONT   = 3'd3,
    ORIENT_BACK    = 3'd4
  } orient_t;

endpackage

// ===== rtl/core/tilt_orientation_detector_unit.sv =====
// Top level of the tilt orientation detector: window sums, detect/confirm
// control, result register and configuration registers.
// Depends on tod_pkg.
//
//   channel  | ports                                    | direction
//   ---------+------------------------------------------+----------
//   input    | in_valid, in_stall, in_x_raw, in_y_raw   | in
//   result   | out_valid, out_stall, out_orientation    | out
//   config   | psel, penable, pwrite, paddr, pwdata ... | in/out
//
// An item is taken every cycle unless in_stall is high; a result decided by
// a window's closing item appears in the next cycle, set by the single result register.
// The input is stalled only when the result register is held by out_stall
// and the next item would close a window.
// Reset (rst_n low, synchronous) clears control state, presets config registers.
// Average compares are done on the window sums against multiples of the
// window size, so no divider is needed.
module tilt_orientation_detector_unit #(
  parameter int unsigned SAMPLES_PER_AVERAGE = tod_pkg::SAMPLES_PER_AVERAGE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input item channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tod_pkg::SAMPLE_W-1:0]    in_x_raw,
  input  logic [tod_pkg::SAMPLE_W-1:0]    in_y_raw,
  // Result item channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tod_pkg::ORIENT_W-1:0]    out_orientation,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tod_pkg::PADDR_W-1:0]     paddr,
  input  logic [tod_pkg::PDATA_W-1:0]     pwdata,
  output logic [tod_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned LOG_N = $clog2(SAMPLES_PER_AVERAGE);
  localparam int unsigned CNT_W = LOG_N;
  localparam int unsigned SUM_W = tod_pkg::SAMPLE_W + LOG_N;
  localparam int unsigned CMP_W = SUM_W + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);
  localparam logic [CMP_W-1:0] N_CMP = CMP_W'(SAMPLES_PER_AVERAGE);

  // Configuration registers
  logic [tod_pkg::THRESH_W-1:0] thresh_r;
  logic [tod_pkg::ROUNDS_W-1:0] rounds_r;
  logic                         cfg_wr;
  tod_pkg::reg_idx_t            cfg_idx;

  // Window and decision state
  logic                         confirming_r, confirming_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic signed [SUM_W-1:0]      x_sum_r, x_sum_nxt;
  logic signed [SUM_W-1:0]      y_sum_r, y_sum_nxt;
  logic [tod_pkg::ROUNDS_W-1:0] round_r, round_nxt;
  tod_pkg::orient_t             cand_r, cand_nxt;

  // Result register
  logic                         out_valid_r, out_valid_nxt;
  tod_pkg::orient_t             res_orient_r, res_orient_nxt;

  // Working signals
  logic                         accept;
  logic                         last;
  logic signed [SUM_W-1:0]      x_add, y_add;
  logic signed [CMP_W-1:0]      x_ext, y_ext, v_ext;
  logic signed [CMP_W-1:0]      lim_pick, lim_keep;
  logic [tod_pkg::ROUNDS_W-1:0] round_inc, need;
  logic                         emit;
  tod_pkg::orient_t             emit_val;

  // Configuration port: always ready, register index from the word address.
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = tod_pkg::reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      tod_pkg::REG_THRESHOLD:      prdata = tod_pkg::PDATA_W'(thresh_r);
      tod_pkg::REG_CONFIRM_ROUNDS: prdata = tod_pkg::PDATA_W'(rounds_r);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= tod_pkg::THRESH_RST;
      rounds_r <= tod_pkg::ROUNDS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tod_pkg::REG_THRESHOLD:      thresh_r <= pwdata[tod_pkg::THRESH_W-1:0];
        tod_pkg::REG_CONFIRM_ROUNDS: rounds_r <= pwdata[tod_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: only an item that closes a window can need the result register.
  assign last     = (cnt_r == CNT_LAST);
  assign in_stall = out_valid_r & out_stall & last;
  assign accept   = in_valid & ~in_stall;

  // Sample accumulation with sign extension.
  assign x_add = x_sum_r + {{(SUM_W - tod_pkg::SAMPLE_W){in_x_raw[tod_pkg::SAMPLE_W-1]}},
                            in_x_raw};
  assign y_add = y_sum_r + {{(SUM_W - tod_pkg::SAMPLE_W){in_y_raw[tod_pkg::SAMPLE_W-1]}},
                            in_y_raw};
  assign x_ext = {{2{x_add[SUM_W-1]}}, x_add};
  assign y_ext = {{2{y_add[SUM_W-1]}}, y_add};

  // A truncated average exceeds th exactly when the sum reaches (th+1)*N, and
  // reaches th in magnitude exactly when the sum reaches th*N.
  assign lim_pick = $signed((CMP_W'(thresh_r) + CMP_W'(1)) * N_CMP);
  assign lim_keep = $signed(CMP_W'(thresh_r) * N_CMP);

  assign v_ext     = (cand_r == tod_pkg::ORIENT_LEFT || cand_r == tod_pkg::ORIENT_RIGHT) ?
                     x_ext : y_ext;
  assign round_inc = round_r + tod_pkg::ROUNDS_W'(1);
  assign need      = (rounds_r == '0) ? tod_pkg::ROUNDS_W'(1) : rounds_r;

  // Window close: detect a candidate or run one confirmation round.
  always_comb begin
    confirming_nxt = confirming_r;
    cnt_nxt        = cnt_r;
    x_sum_nxt      = x_sum_r;
    y_sum_nxt      = y_sum_r;
    round_nxt      = round_r;
    cand_nxt       = cand_r;
    emit           = 1'b0;
    emit_val       = tod_pkg::ORIENT_UNKNOWN;
    if (accept) begin
      if (!last) begin
        cnt_nxt   = cnt_r + CNT_W'(1);
        x_sum_nxt = x_add;
        y_sum_nxt = y_add;
      end else begin
        cnt_nxt   = '0;
        x_sum_nxt = '0;
        y_sum_nxt = '0;
        if (!confirming_r) begin
          if (x_ext >= lim_pick) begin
            cand_nxt = tod_pkg::ORIENT_LEFT;
          end else if (x_ext <= -lim_pick) begin
            cand_nxt = tod_pkg::ORIENT_RIGHT;
          end else if (y_ext >= lim_pick) begin
            cand_nxt = tod_pkg::ORIENT_FRONT;
          end else if (y_ext <= -lim_pick) begin
            cand_nxt = tod_pkg::ORIENT_BACK;
          end else begin
            emit = 1'b1;
          end
          if (!emit) begin
            confirming_nxt = 1'b1;
            round_nxt      = '0;
          end
        end else if (!(v_ext >= lim_keep || v_ext <= -lim_keep)) begin
          // Tilt lost during confirmation.
          emit           = 1'b1;
          confirming_nxt = 1'b0;
          round_nxt      = '0;
          cand_nxt       = tod_pkg::ORIENT_UNKNOWN;
        end else if (round_inc >= need) begin
          emit           = 1'b1;
          emit_val       = cand_r;
          confirming_nxt = 1'b0;
          round_nxt      = '0;
          cand_nxt       = tod_pkg::ORIENT_UNKNOWN;
        end else begin
          round_nxt = round_inc;
        end
      end
    end
  end

  // Result register: load on a decision, drop once taken.
  always_comb begin
    out_valid_nxt  = out_valid_r & out_stall;
    res_orient_nxt = res_orient_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      res_orient_nxt = emit_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      confirming_r <= 1'b0;
      cnt_r        <= '0;
      x_sum_r      <= '0;
      y_sum_r      <= '0;
      round_r      <= '0;
      cand_r       <= tod_pkg::ORIENT_UNKNOWN;
      out_valid_r  <= 1'b0;
    end else begin
      confirming_r <= confirming_nxt;
      cnt_r        <= cnt_nxt;
      x_sum_r      <= x_sum_nxt;
      y_sum_r      <= y_sum_nxt;
      round_r      <= round_nxt;
      cand_r       <= cand_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_orient_r <= res_orient_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_orientation = res_orient_r;

endmodule

// ===== rtl/core/tod_checker.sv =====
// Port-level checker for the tilt orientation detector, bound to the top level.
// Depends on tod_pkg and tilt_orientation_detector_unit.
module tod_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [tod_pkg::SAMPLE_W-1:0] in_x_raw,
  input logic [tod_pkg::SAMPLE_W-1:0] in_y_raw,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tod_pkg::ORIENT_W-1:0] out_orientation,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [tod_pkg::PADDR_W-1:0]  paddr,
  input logic [tod_pkg::PDATA_W-1:0]  pwdata,
  input logic [tod_pkg::PDATA_W-1:0]  prdata,
  input logic                         pready
);

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  // A new result item only follows an accepted input item.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result item without an accepted input item");

  // Only defined orientation codes leave the block.
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_orientation <= tod_pkg::ORIENT_BACK)
    else $error("undefined orientation code");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present after reset");

  // The input side is never held while the result side is free.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with a free result register");

endmodule

bind tilt_orientation_detector_unit tod_checker u_tod_checker (.*);

// ===== bench/tb.sv =====
// Testbench for tilt_orientation_detector_unit: streams paired X/Y samples, programs
// threshold and confirm rounds over the APB port and checks every orientation item.
// Depends on tod_pkg and tilt_orientation_detector_unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN          = tod_pkg::SAMPLES_PER_AVERAGE_DEF;
  localparam int IDLE_PCT     = 21;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1100;
  localparam int FULL_RATE_ITEMS = 250;

  logic                         clk      = 1'b0;
  logic                         rst_n    = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [tod_pkg::SAMPLE_W-1:0] in_x_raw = '0;
  logic [tod_pkg::SAMPLE_W-1:0] in_y_raw = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [tod_pkg::ORIENT_W-1:0] out_orientation;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [tod_pkg::PADDR_W-1:0]  paddr   = '0;
  logic [tod_pkg::PDATA_W-1:0]  pwdata  = '0;
  logic [tod_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;

  // Register copies and detector state as the bench expects them.
  logic [tod_pkg::THRESH_W-1:0] thr_cfg    = tod_pkg::THRESH_RST;
  logic [tod_pkg::ROUNDS_W-1:0] rounds_cfg = tod_pkg::ROUNDS_RST;
  bit                           in_confirm = 1'b0;
  int                           win_fill   = 0;
  int                           x_acc      = 0;
  int                           y_acc      = 0;
  logic [3:0]                   rounds_passed = '0;
  tod_pkg::orient_t             cand_dir   = tod_pkg::ORIENT_UNKNOWN;
  tod_pkg::orient_t             orient_q[$];

  int err_count    = 0;
  int results_seen = 0;
  int items_sent   = 0;
  int cycles       = 0;
  bit quiet        = 1'b0;

  always #5 clk = ~clk;

  tilt_orientation_detector_unit #(
    .SAMPLES_PER_AVERAGE(WIN)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_x_raw(in_x_raw),
    .in_y_raw(in_y_raw),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_orientation(out_orientation),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Advance the expected detector state by one sample and queue any decision.
  function automatic void track_orientation(logic [tod_pkg::SAMPLE_W-1:0] xr,
                                            logic [tod_pkg::SAMPLE_W-1:0] yr);
    int               xa;
    int               ya;
    int               th;
    int               v;
    int               need;
    tod_pkg::orient_t pick;
    x_acc += int'(signed'(xr));
    y_acc += int'(signed'(yr));
    win_fill++;
    if (win_fill < WIN) return;
    // Window closed: averages truncate toward zero.
    xa = x_acc / WIN;
    ya = y_acc / WIN;
    x_acc = 0;
    y_acc = 0;
    win_fill = 0;
    th = int'(thr_cfg);
    if (!in_confirm) begin
      pick = tod_pkg::ORIENT_UNKNOWN;
      if (xa > th) pick = tod_pkg::ORIENT_LEFT;
      else if (xa < -th) pick = tod_pkg::ORIENT_RIGHT;
      else if (ya > th) pick = tod_pkg::ORIENT_FRONT;
      else if (ya < -th) pick = tod_pkg::ORIENT_BACK;
      if (pick == tod_pkg::ORIENT_UNKNOWN) begin
        orient_q.push_back(tod_pkg::ORIENT_UNKNOWN);
      end else begin
        cand_dir = pick;
        in_confirm = 1'b1;
        rounds_passed = '0;
      end
      return;
    end
    // Confirm phase: the candidate's axis must hold its magnitude.
    v = (cand_dir == tod_pkg::ORIENT_LEFT || cand_dir == tod_pkg::ORIENT_RIGHT) ? xa : ya;
    if (-th < v && v < th) begin
      in_confirm = 1'b0;
      rounds_passed = '0;
      cand_dir = tod_pkg::ORIENT_UNKNOWN;
      orient_q.push_back(tod_pkg::ORIENT_UNKNOWN);
      return;
    end
    rounds_passed = rounds_passed + 4'd1;
    need = (rounds_cfg == 0) ? 1 : int'(rounds_cfg);
    if (int'(rounds_passed) >= need) begin
      orient_q.push_back(cand_dir);
      in_confirm = 1'b0;
      rounds_passed = '0;
      cand_dir = tod_pkg::ORIENT_UNKNOWN;
    end
  endfunction

  // Sample around a mean, clamped to the six-bit signed range.
  function automatic logic [tod_pkg::SAMPLE_W-1:0] near(int mean, int spread);
    int v;
    v = mean + int'($urandom_range(2 * spread)) - spread;
    if (v > 31) v = 31;
    if (v < -32) v = -32;
    return v[tod_pkg::SAMPLE_W-1:0];
  endfunction

  // Result checker: every accepted item is matched against the oldest expectation.
  always @(posedge clk) begin
    tod_pkg::orient_t exp_dir;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (orient_q.size() == 0) begin
        $error("orientation: unexpected item %0d with nothing expected", out_orientation);
        err_count++;
      end else begin
        exp_dir = orient_q.pop_front();
        if (out_orientation !== exp_dir) begin
          $error("orientation: expected %0d, actual %0d", exp_dir, out_orientation);
          err_count++;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one sample and hold it until taken, then maybe idle a while.
  task automatic send_sample(logic [tod_pkg::SAMPLE_W-1:0] xr,
                             logic [tod_pkg::SAMPLE_W-1:0] yr);
    in_valid <= 1'b1;
    in_x_raw <= xr;
    in_y_raw <= yr;
    do @(posedge clk); while (in_stall);
    track_orientation(xr, yr);
    items_sent++;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  task automatic send_window(int xm, int ym, int spread);
    repeat (WIN) send_sample(near(xm, spread), near(ym, spread));
  endtask

  // Fill the current partial window with noise so the next one starts clean.
  task automatic align_window();
    while (win_fill != 0) send_sample(6'($urandom_range(63)), 6'($urandom_range(63)));
  endtask

  // Stop offering items, wait for every expected result and the block's latency.
  task automatic settle();
    in_valid <= 1'b0;
    while (orient_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic cfg_access(bit wr, tod_pkg::reg_idx_t idx, logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(tod_pkg::reg_idx_t idx);
    logic [31:0] rd;
    cfg_access(1'b0, idx, '0, rd);
    if (idx == tod_pkg::REG_THRESHOLD) begin
      if (rd[tod_pkg::THRESH_W-1:0] !== thr_cfg) begin
        $error("threshold: expected %0d, actual %0d", thr_cfg, rd[tod_pkg::THRESH_W-1:0]);
        err_count++;
      end
    end else if (rd[tod_pkg::ROUNDS_W-1:0] !== rounds_cfg) begin
      $error("confirm_rounds: expected %0d, actual %0d", rounds_cfg,
             rd[tod_pkg::ROUNDS_W-1:0]);
      err_count++;
    end
  endtask

  task automatic write_reg(tod_pkg::reg_idx_t idx, logic [31:0] word);
    logic [31:0] unused;
    cfg_access(1'b1, idx, word, unused);
    if (idx == tod_pkg::REG_THRESHOLD) thr_cfg = word[tod_pkg::THRESH_W-1:0];
    else rounds_cfg = word[tod_pkg::ROUNDS_W-1:0];
    check_reg(idx);
  endtask

  // Pick a new threshold and round count, extremes included.
  task automatic retune();
    logic [31:0] word;
    int          roll;
    word = $urandom;
    roll = $urandom_range(99);
    if (roll < 15) word[5:0] = 6'd0;
    else if (roll < 25) word[5:0] = 6'($urandom_range(63, 32));
    else if (roll < 30) word[5:0] = 6'h3F;
    else word[5:0] = 6'($urandom_range(16));
    write_reg(tod_pkg::REG_THRESHOLD, word);
    word = $urandom;
    roll = $urandom_range(99);
    if (roll < 10) word[3:0] = 4'd0;
    else if (roll < 60) word[3:0] = 4'($urandom_range(3, 1));
    else if (roll < 85) word[3:0] = 4'($urandom_range(8, 4));
    else word[3:0] = 4'($urandom_range(15, 9));
    write_reg(tod_pkg::REG_CONFIRM_ROUNDS, word);
  endtask

  // A tilt held along one direction for detect plus all confirm windows,
  // optionally dropping toward level in one of the confirm windows.
  task automatic run_tilt(tod_pkg::orient_t dir, bit break_off);
    int mag;
    int quarter;
    int off;
    int spread;
    int windows;
    int cut;
    int amp;
    mag = int'(thr_cfg) + 1 + int'($urandom_range(6));
    if (mag > 31) mag = 31;
    quarter = int'(thr_cfg) / 2;
    off = int'($urandom_range(2 * quarter)) - quarter;
    spread = $urandom_range(3);
    windows = 1 + ((rounds_cfg == 0) ? 1 : int'(rounds_cfg));
    cut = break_off ? int'($urandom_range(windows - 1, 1)) : windows;
    for (int w = 0; w < windows && w <= cut; w++) begin
      amp = (w == cut) ? int'($urandom_range(2 * quarter)) - quarter : mag;
      case (dir)
        tod_pkg::ORIENT_LEFT: begin
          send_window(amp, off, spread);
        end
        tod_pkg::ORIENT_RIGHT: begin
          send_window(-amp, off, spread);
        end
        tod_pkg::ORIENT_FRONT: begin
          send_window(off, amp, spread);
        end
        default: begin
          send_window(off, -amp, spread);
        end
      endcase
    end
  endtask

  // Registers read back their reset values.
  task automatic test_reset_values();
    check_reg(tod_pkg::REG_THRESHOLD);
    check_reg(tod_pkg::REG_CONFIRM_ROUNDS);
  endtask

  // Full-scale samples with threshold zero and zero confirm rounds,
  // then a threshold above the average range.
  task automatic test_extremes();
    write_reg(tod_pkg::REG_THRESHOLD, 32'hFFFF_FFC0);
    write_reg(tod_pkg::REG_CONFIRM_ROUNDS, 32'hFFFF_FFF0);
    repeat (WIN) send_sample(6'h1F, 6'h20);
    repeat (WIN) send_sample(6'h20, 6'h1F);
    settle();
    write_reg(tod_pkg::REG_THRESHOLD, 32'h0000_003F);
    for (int i = 0; i < WIN; i++) begin
      send_sample((i % 2) ? 6'h3F : 6'h00, (i % 2) ? 6'h2A : 6'h15);
    end
    settle();
  endtask

  // Registers rewritten in the middle of a confirmation.
  task automatic test_change_while_confirming();
    write_reg(tod_pkg::REG_THRESHOLD, 32'd5);
    write_reg(tod_pkg::REG_CONFIRM_ROUNDS, 32'd15);
    align_window();
    repeat (4) send_window(20, 0, 1);
    settle();
    // Fewer rounds than already passed: the next good window reports.
    write_reg(tod_pkg::REG_CONFIRM_ROUNDS, 32'd2);
    send_window(20, 0, 1);
    settle();
    write_reg(tod_pkg::REG_CONFIRM_ROUNDS, 32'd15);
    repeat (2) send_window(0, -20, 1);
    settle();
    // Threshold raised past the held tilt: the confirmation fails.
    write_reg(tod_pkg::REG_THRESHOLD, 32'd63);
    send_window(0, -20, 1);
    settle();
  endtask

  // Mostly well-formed tilts with random content, plus noise and misaligned bursts.
  task automatic test_random_tilts(int count);
    int               target;
    int               episode;
    int               roll;
    tod_pkg::orient_t dir;
    target = items_sent + count;
    episode = 0;
    while (items_sent < target) begin
      if (episode % 10 == 0) begin
        settle();
        retune();
      end
      episode++;
      roll = $urandom_range(99);
      if (roll < 70) begin
        align_window();
        dir = tod_pkg::orient_t'($urandom_range(4, 1));
        run_tilt(dir, $urandom_range(99) < 25);
      end else if (roll < 85) begin
        repeat (WIN) send_sample(6'($urandom_range(63)), 6'($urandom_range(63)));
      end else begin
        repeat ($urandom_range(2 * WIN, 1)) begin
          send_sample(6'($urandom_range(63)), 6'($urandom_range(63)));
        end
      end
    end
    settle();
  endtask

  // The same traffic with neither side idling.
  task automatic test_full_rate();
    quiet = 1'b1;
    test_random_tilts(FULL_RATE_ITEMS);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_change_while_confirming();
    test_random_tilts(RANDOM_ITEMS);
    test_full_rate();
    settle();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/tod_pkg.sv
rtl/core/tilt_orientation_detector_unit.sv
rtl/core/tod_checker.sv
bench/tb.sv
